/* hw/rtl/point_projection_box_select_top_macros.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef POINT_PROJECTION_BOX_SELECT_TOP_MACROS_SVH
`define POINT_PROJECTION_BOX_SELECT_TOP_MACROS_SVH

// Implication checked at every edge outside reset.
`define PPBS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define PPBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ppbs_pkg.sv */
//------------------------------------------------------------------------------
// ppbs_pkg
// Register indexes and widths shared by the box-select pipeline.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ppbs_pkg;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CLIP_X = 3'd0,
      CSR_CLIP_Y = 3'd1,
      CSR_CLIP_W = 3'd2,
      CSR_VP_W   = 3'd3,
      CSR_VP_H   = 3'd4,
      CSR_CORNER_START = 3'd5,
      CSR_CORNER_END   = 3'd6
   } csr_idx_type;
   localparam int VP_BITS = 15;
   localparam logic [VP_BITS-1:0] VP_RESET = 15'd1024;
   localparam int PIX_BITS = 16;
endpackage
`default_nettype wire

/* hw/rtl/point_projection_box_select_top.sv */
//------------------------------------------------------------------------------
// point_projection_box_select_top
// Projects a point to viewport pixels and tests it against a rectangle.
//------------------------------------------------------------------------------
// Usage:
//   req_ channel carries one point per beat (id and Q16.8 position).
//   rsp_ channel returns one beat per point: the id and the inside flag.
//   csr_ channel writes the registers; write only while the block is idle.
// Throughput: one point per cycle, set by the fully pipelined multiply and
//   compare stages (nine products, sum, ratio terms, cross products, compare).
// When rsp_ready is low and the output stage holds a beat, the whole pipeline
//   holds; req_ready drops only when the output stage is full and stalled.
// Reset clears all valid bits and loads the register defaults (viewport
//   1024 x 1024, everything else zero).
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "point_projection_box_select_top_macros.svh"
module point_projection_box_select_top #(
   parameter int INDEX_BITS = 24,
   parameter int POS_BITS = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [INDEX_BITS-1:0]               req_point_id,
   input  wire logic signed [POS_BITS-1:0]          req_pos_x,
   input  wire logic signed [POS_BITS-1:0]          req_pos_y,
   input  wire logic signed [POS_BITS-1:0]          req_pos_z,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [INDEX_BITS-1:0]                    rsp_result_id,
   output logic                                     rsp_inside_res,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ppbs_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [ppbs_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import ppbs_pkg::*;
   localparam int PROD_BITS = POS_BITS + 16;
   localparam int TERM_BITS = POS_BITS + 19;   // three products plus constant
   localparam int NUM_BITS = TERM_BITS + 3;
   localparam int DEPTH = 6;

   logic [63:0] cx_ff, cy_ff, cw_ff;
   logic [VP_BITS-1:0] vpw_ff, vph_ff;
   logic [31:0] cs_ff, ce_ff;
   logic [PIX_BITS-1:0] lox, hix, loy, hiy;

   logic advance;
   logic [DEPTH-1:0] vld_ff;
   logic [INDEX_BITS-1:0] id_ff [DEPTH];

   logic signed [PROD_BITS-1:0] pr_ff [3][3];
   logic signed [TERM_BITS-1:0] k_ff [3];
   logic signed [TERM_BITS-1:0] t_ff [3];
   logic signed [NUM_BITS-1:0] nx, ny, dd;
   logic signed [TERM_BITS-1:0] w_eff;
   logic in_x, in_y;
   logic signed [POS_BITS-1:0] pos [3];
   logic [63:0] coefs [3];

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0; cy_ff <= '0; cw_ff <= '0;
         vpw_ff <= VP_RESET; vph_ff <= VP_RESET;
         cs_ff <= '0; ce_ff <= '0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_CLIP_X: cx_ff <= csr_data;
            CSR_CLIP_Y: cy_ff <= csr_data;
            CSR_CLIP_W: cw_ff <= csr_data;
            CSR_VP_W: vpw_ff <= csr_data[VP_BITS-1:0];
            CSR_VP_H: vph_ff <= csr_data[VP_BITS-1:0];
            CSR_CORNER_START: cs_ff <= csr_data[31:0];
            CSR_CORNER_END: ce_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      lox = (cs_ff[15:0] < ce_ff[15:0]) ? cs_ff[15:0] : ce_ff[15:0];
      hix = (cs_ff[15:0] < ce_ff[15:0]) ? ce_ff[15:0] : cs_ff[15:0];
      loy = (cs_ff[31:16] < ce_ff[31:16]) ? cs_ff[31:16] : ce_ff[31:16];
      hiy = (cs_ff[31:16] < ce_ff[31:16]) ? ce_ff[31:16] : cs_ff[31:16];
   end

   // whole pipe moves unless the output beat is held
   assign advance = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = advance;

   assign pos[0] = req_pos_x;
   assign pos[1] = req_pos_y;
   assign pos[2] = req_pos_z;
   assign coefs[0] = cx_ff;
   assign coefs[1] = cy_ff;
   assign coefs[2] = cw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         id_ff[0] <= req_point_id;
         for (int i = 1; i < DEPTH; i++) id_ff[i] <= id_ff[i-1];
         // stage 1: nine products and the three constant terms
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               pr_ff[r][c] <= PROD_BITS'($signed(coefs[r][16*c +: 16]) * pos[c]);
            end
            k_ff[r] <= TERM_BITS'($signed(coefs[r][63:48])) <<< 8;
         end
         // stage 2: clip terms
         for (int r = 0; r < 3; r++) begin
            t_ff[r] <= TERM_BITS'(pr_ff[r][0]) + TERM_BITS'(pr_ff[r][1])
                       + TERM_BITS'(pr_ff[r][2]) + k_ff[r];
         end
      end
   end

   // numerators and denominator, w == 0 taken as 1.0 (made positive when registered)
   always_comb begin
      w_eff = (t_ff[2] == '0) ? TERM_BITS'(65536) : t_ff[2];
      nx = NUM_BITS'(t_ff[0]) + NUM_BITS'(w_eff);
      ny = NUM_BITS'(w_eff) - NUM_BITS'(t_ff[1]);
      dd = NUM_BITS'(w_eff) <<< 1;
   end

   logic signed [NUM_BITS-1:0] nx_ff, ny_ff, d_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         nx_ff <= dd[NUM_BITS-1] ? -nx : nx;
         ny_ff <= dd[NUM_BITS-1] ? -ny : ny;
         d_ff <= dd[NUM_BITS-1] ? -dd : dd;
      end
   end

   ppbs_axis_test #(.NUM_BITS(NUM_BITS)) u_axis_x (
      .clock(clock), .advance(advance), .num(nx_ff), .den(d_ff),
      .scale(vpw_ff), .lo(lox), .hi(hix), .in_range(in_x));
   ppbs_axis_test #(.NUM_BITS(NUM_BITS)) u_axis_y (
      .clock(clock), .advance(advance), .num(ny_ff), .den(d_ff),
      .scale(vph_ff), .lo(loy), .hi(hiy), .in_range(in_y));

   assign rsp_valid = vld_ff[DEPTH-1];
   assign rsp_result_id = id_ff[DEPTH-1];
   assign rsp_inside_res = in_x && in_y;

   `PPBS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_id), "held beat changed")
   `PPBS_ASSERT_IMP(a_ready, clock, reset, !req_ready, rsp_valid && !rsp_ready, "input stalled without output stall")
   `PPBS_ASSERT_NEXT(a_flow, clock, reset, req_valid && req_ready, vld_ff[0], "accepted beat not tracked")
endmodule
`default_nettype wire

/* hw/rtl/ppbs_axis_test.sv */
//------------------------------------------------------------------------------
// ppbs_axis_test
// Pipelined exact test lo <= num*scale/den <= hi with den > 0.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ppbs_axis_test #(
   parameter int NUM_BITS = 60
) (
   input  wire logic                          clock,
   input  wire logic                          advance,
   input  wire logic signed [NUM_BITS-1:0]    num,
   input  wire logic [NUM_BITS-1:0]           den,
   input  wire logic [ppbs_pkg::VP_BITS-1:0]  scale,
   input  wire logic [ppbs_pkg::PIX_BITS-1:0] lo,
   input  wire logic [ppbs_pkg::PIX_BITS-1:0] hi,
   output logic                               in_range
);
   import ppbs_pkg::*;
   localparam int PW = NUM_BITS + PIX_BITS + 2;
   // stage 1: split the wide factors into halves against narrow factors
   localparam int HB = (NUM_BITS + 1) / 2;
   logic signed [PW-1:0] p_lo_ff, p_hi_ff, l_lo_ff, l_hi_ff, h_lo_ff, h_hi_ff;
   logic signed [PW-1:0] p_ff, l_ff, h_ff;
   logic signed [HB:0] num_lo;
   logic [HB:0] den_lo;
   logic signed [NUM_BITS-HB:0] num_hi;
   logic [NUM_BITS-HB:0] den_hi;
   logic inside_ff;

   assign num_lo = $signed({1'b0, num[HB-1:0]});
   assign den_lo = {1'b0, den[HB-1:0]};
   // upper half keeps the sign of num
   assign num_hi = $signed({num[NUM_BITS-1], num[NUM_BITS-1:HB]});
   assign den_hi = {1'b0, den[NUM_BITS-1:HB]};

   always_ff @(posedge clock) begin
      if (advance) begin
         p_lo_ff <= PW'(num_lo * $signed({1'b0, scale}));
         p_hi_ff <= PW'(num_hi * $signed({1'b0, scale}));
         l_lo_ff <= PW'($signed({1'b0, den_lo}) * $signed({1'b0, lo}));
         l_hi_ff <= PW'($signed({1'b0, den_hi}) * $signed({1'b0, lo}));
         h_lo_ff <= PW'($signed({1'b0, den_lo}) * $signed({1'b0, hi}));
         h_hi_ff <= PW'($signed({1'b0, den_hi}) * $signed({1'b0, hi}));
         p_ff <= (p_hi_ff <<< HB) + p_lo_ff;
         l_ff <= (l_hi_ff <<< HB) + l_lo_ff;
         h_ff <= (h_hi_ff <<< HB) + h_lo_ff;
         inside_ff <= (p_ff >= l_ff) && (p_ff <= h_ff);
      end
   end
   assign in_range = inside_ff;
endmodule
`default_nettype wire

/* dv/point_projection_box_select_top_tb.sv */
//------------------------------------------------------------------------------
// point_projection_box_select_top_tb
// Streams points through the box-select pipeline under random and directed
// register settings. A local exact-arithmetic projection predicts the inside
// flag of every point, and each result beat is compared in order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module point_projection_box_select_top_tb;
   import ppbs_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [23:0] id;
      logic        flag;
   } hit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [23:0] req_point_id = '0;
   logic signed [23:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [23:0] rsp_result_id;
   logic rsp_inside_res;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // local copy of the register file
   logic [63:0] coef_x, coef_y, coef_w;
   logic [14:0] vp_w, vp_h;
   logic [31:0] corner_a, corner_b;

   hit_type hit_q[$];
   int   mismatches = 0;
   bit   no_idle = 0;
   bit   rsp_hold = 0;

   always #6 clock = ~clock;

   point_projection_box_select_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_id(req_point_id), .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_id(rsp_result_id), .rsp_inside_res(rsp_inside_res),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   function automatic longint clip_sum(logic [63:0] c, longint px, longint py, longint pz);
      return longint'($signed(c[15:0])) * px + longint'($signed(c[31:16])) * py
           + longint'($signed(c[47:32])) * pz + longint'($signed(c[63:48])) * 256;
   endfunction

   // lo <= num*scale/den <= hi, by cross-multiplying
   function automatic bit axis_hit(longint num, longint den, longint scale,
                                   longint lo, longint hi);
      logic signed [127:0] sn, ad, p;
      sn = (den < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      p  = sn * scale;
      return (p >= lo * ad) && (p <= hi * ad);
   endfunction

   function automatic bit project_inside(logic signed [23:0] x, logic signed [23:0] y,
                                         logic signed [23:0] z);
      longint cx, cy, cw, lox, hix, loy, hiy;
      cx = clip_sum(coef_x, longint'(x), longint'(y), longint'(z));
      cy = clip_sum(coef_y, longint'(x), longint'(y), longint'(z));
      cw = clip_sum(coef_w, longint'(x), longint'(y), longint'(z));
      if (cw == 0) cw = 65536;  // zero w: no divide
      lox = longint'((corner_a[15:0] < corner_b[15:0]) ? corner_a[15:0] : corner_b[15:0]);
      hix = longint'((corner_a[15:0] < corner_b[15:0]) ? corner_b[15:0] : corner_a[15:0]);
      loy = longint'((corner_a[31:16] < corner_b[31:16]) ? corner_a[31:16] : corner_b[31:16]);
      hiy = longint'((corner_a[31:16] < corner_b[31:16]) ? corner_b[31:16] : corner_a[31:16]);
      return axis_hit(cx + cw, 2 * cw, longint'(vp_w), lox, hix)
          && axis_hit(cw - cy, 2 * cw, longint'(vp_h), loy, hiy);
   endfunction

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CLIP_X:       coef_x = val;
         CSR_CLIP_Y:       coef_y = val;
         CSR_CLIP_W:       coef_w = val;
         CSR_VP_W:         vp_w = val[14:0];
         CSR_VP_H:         vp_h = val[14:0];
         CSR_CORNER_START: corner_a = val[31:0];
         CSR_CORNER_END:   corner_b = val[31:0];
         default: ;
      endcase
   endtask

   task automatic send_point(logic [23:0] id, logic signed [23:0] x,
                             logic signed [23:0] y, logic signed [23:0] z);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_point_id <= id;
      req_pos_x    <= x;
      req_pos_y    <= y;
      req_pos_z    <= z;
      do @(posedge clock); while (!req_ready);
      hit_q.push_back('{id: id, flag: project_inside(x, y, z)});
   endtask

   task automatic drain();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (hit_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // identity-like transform with a mild perspective term
   task automatic load_view();
      write_reg(CSR_CLIP_X, {16'($urandom_range(0, 128) - 64), 16'h0,
                             16'($urandom_range(0, 128) - 64), 16'($urandom_range(128, 512))});
      write_reg(CSR_CLIP_Y, {16'($urandom_range(0, 128) - 64), 16'($urandom_range(0, 64) - 32),
                             16'($urandom_range(128, 512)), 16'h0});
      write_reg(CSR_CLIP_W, {16'($urandom_range(192, 512)), 16'($urandom_range(0, 64) - 32),
                             16'h0, 16'h0});
      write_reg(CSR_VP_W, 64'($urandom_range(1, 2048)));
      write_reg(CSR_VP_H, 64'($urandom_range(1, 2048)));
      write_reg(CSR_CORNER_START,
                64'({16'($urandom_range(0, vp_h)), 16'($urandom_range(0, vp_w))}));
      write_reg(CSR_CORNER_END,
                64'({16'($urandom_range(0, vp_h)), 16'($urandom_range(0, vp_w))}));
   endtask

   task automatic load_random();
      write_reg(CSR_CLIP_X, {$urandom, $urandom});
      write_reg(CSR_CLIP_Y, {$urandom, $urandom});
      write_reg(CSR_CLIP_W, {$urandom, $urandom});
      write_reg(CSR_VP_W, {$urandom, $urandom});
      write_reg(CSR_VP_H, {$urandom, $urandom});
      write_reg(CSR_CORNER_START, {$urandom, $urandom});
      write_reg(CSR_CORNER_END, {$urandom, $urandom});
   endtask

   task automatic send_near(int span);
      send_point(24'($urandom), 24'($urandom_range(0, 2 * span) - span),
                 24'($urandom_range(0, 2 * span) - span),
                 24'($urandom_range(0, 2 * span) - span));
   endtask

   task automatic test_defaults();
      send_point(24'h0, 24'sh0, 24'sh0, 24'sh0);
      send_point(24'hFFFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
      send_point(24'h5A5A5A, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
      drain();
   endtask

   task automatic test_special_cases();
      // zero w: clip x/y used directly, rect covers center pixel
      write_reg(CSR_CLIP_X, 64'h0000_0000_0000_0000);
      write_reg(CSR_CLIP_W, 64'h0);
      write_reg(CSR_CORNER_START, 64'({16'd500, 16'd500}));
      write_reg(CSR_CORNER_END, 64'({16'd524, 16'd524}));
      send_point(24'd1, 24'sh0, 24'sh0, 24'sh0);
      send_point(24'd2, 24'sh7FFFFF, 24'sh800000, 24'sh0);
      drain();
      // identity, w = 1.0, bounds exactly on the pixel
      write_reg(CSR_CLIP_X, 64'h0000_0000_0000_0100);
      write_reg(CSR_CLIP_Y, 64'h0000_0000_0100_0000);
      write_reg(CSR_CLIP_W, 64'h0100_0000_0000_0000);
      write_reg(CSR_CORNER_START, 64'({16'd512, 16'd512}));
      write_reg(CSR_CORNER_END, 64'({16'd512, 16'd512}));
      send_point(24'd3, 24'sh0, 24'sh0, 24'sh0);
      send_point(24'd4, 24'sh1, 24'sh0, 24'sh0);
      drain();
      // negative w
      write_reg(CSR_CLIP_W, 64'hFF00_0000_0000_0000);
      send_point(24'd5, 24'sh0, 24'sh0, 24'sh0);
      send_point(24'd6, -24'sd128, 24'sd64, 24'sh0);
      drain();
      // corners reversed, full viewport edges
      write_reg(CSR_CORNER_START, 64'({16'hFFFF, 16'hFFFF}));
      write_reg(CSR_CORNER_END, 64'h0);
      send_point(24'd7, 24'sd100, -24'sd200, 24'sh0);
      send_point(24'd8, 24'sh800000, 24'sh0, 24'sh0);
      drain();
      // zero viewport size, extreme size, and an unmapped index
      write_reg(CSR_VP_W, 64'h8000);
      write_reg(CSR_VP_H, 64'd16384);
      write_reg(CSR_UNMAPPED, {$urandom, $urandom});
      send_point(24'd9, 24'sd256, 24'sd256, 24'sh0);
      send_point(24'd10, -24'sd256, -24'sd256, 24'sh0);
      drain();
      write_reg(CSR_VP_W, 64'd1);
      write_reg(CSR_VP_H, 64'd0);
      send_point(24'd11, 24'sd0, 24'sd256, 24'sh0);
      drain();
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 12; ph++) begin
         no_idle = (ph % 4 == 3);
         if (ph % 3 == 2) load_random();
         else load_view();
         for (int i = 0; i < 110; i++) begin
            if ($urandom_range(0, 9) < 8) send_near(600);
            else send_point(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
         end
         drain();
      end
      no_idle = 0;
   endtask

   task automatic test_backpressure();
      load_view();
      rsp_hold = 1;
      fork
         begin
            repeat (150) @(posedge clock);
            rsp_hold = 0;
         end
         for (int i = 0; i < 40; i++) send_near(400);
      join
      drain();
      // sender pauses until everything has returned, then resumes
      for (int i = 0; i < 10; i++) send_near(400);
      drain();
      for (int i = 0; i < 10; i++) send_near(400);
      drain();
   endtask

   // result side: random stalls, long hold when asked
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
         end else begin
            n = no_idle ? 0 : $urandom_range(0, 8);
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            do @(posedge clock); while (!(rsp_valid && rsp_ready) && !rsp_hold);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (hit_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: id=%h inside=%b", rsp_result_id, rsp_inside_res);
         end else begin
            hit_type e;
            e = hit_q.pop_front();
            if (e.id !== rsp_result_id || e.flag !== rsp_inside_res) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp id=%h inside=%b, got id=%h inside=%b",
                           e.id, e.flag, rsp_result_id, rsp_inside_res);
            end
         end
      end
   end

   initial begin
      coef_x = '0;
      coef_y = '0;
      coef_w = '0;
      vp_w = VP_RESET;
      vp_h = VP_RESET;
      corner_a = '0;
      corner_b = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_special_cases();
      test_random_phases();
      test_backpressure();
      if (mismatches == 0 && hit_q.size() == 0)
         $display("PASS point_projection_box_select_top");
      else
         $display("FAIL point_projection_box_select_top");
      $finish;
   end

   initial begin
      #6000000;
      $display("FAIL point_projection_box_select_top");
      $finish;
   end
endmodule
